[rtl/hc2_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hc2_pkg
// shared types, register indexes and mod 26 helpers for the 2x2 hill cipher
// ----------------------------------------------------------------------------
package hc2_pkg;

    localparam int unsigned LETTER_W = 5;
    localparam int unsigned PROD_W   = 10;
    localparam int unsigned SUM_W    = 11;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 5;

    localparam logic [LETTER_W-1:0] ALPHA_SIZE = 5'd26;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_R0C0 = 3'd0,
        CFG_KEY_R0C1 = 3'd1,
        CFG_KEY_R1C0 = 3'd2,
        CFG_KEY_R1C1 = 3'd3,
        CFG_DECRYPT  = 3'd4
    } t_cfg_idx;

    // key and mode as seen by the datapath
    typedef struct packed {
        logic [LETTER_W-1:0] k00;
        logic [LETTER_W-1:0] k01;
        logic [LETTER_W-1:0] k10;
        logic [LETTER_W-1:0] k11;
        logic                decrypt;
    } t_key_cfg;

    // fold a raw 5-bit code into 0..25
    function automatic logic [LETTER_W-1:0] reduce5(input logic [LETTER_W-1:0] v);
        return (v >= ALPHA_SIZE) ? v - ALPHA_SIZE : v;
    endfunction

    // v mod 26 for v below 1680 (datapath sums stay under 1251): reciprocal
    // 78/2048 underestimates the quotient by at most one, so one compare and
    // subtract finishes it
    function automatic logic [LETTER_W-1:0] mod26(input logic [SUM_W-1:0] v);
        logic [16:0]      p;
        logic [5:0]       q;
        logic [SUM_W-1:0] r;
        p = 17'(v) * 17'd78;
        q = p[16:11];
        r = v - 11'(q) * 11'(ALPHA_SIZE);
        if (r >= 11'(ALPHA_SIZE)) begin
            r = r - 11'(ALPHA_SIZE);
        end
        return r[LETTER_W-1:0];
    endfunction

    // additive inverse mod 26 of a value in 0..25
    function automatic logic [LETTER_W-1:0] neg26(input logic [LETTER_W-1:0] v);
        return (v == '0) ? '0 : ALPHA_SIZE - v;
    endfunction

    // multiplicative inverse mod 26, zero when there is none
    function automatic logic [LETTER_W-1:0] inv26(input logic [LETTER_W-1:0] v);
        logic [LETTER_W-1:0] r;
        case (v)
            5'd1:    r = 5'd1;
            5'd3:    r = 5'd9;
            5'd5:    r = 5'd21;
            5'd7:    r = 5'd15;
            5'd9:    r = 5'd3;
            5'd11:   r = 5'd19;
            5'd15:   r = 5'd7;
            5'd17:   r = 5'd23;
            5'd19:   r = 5'd11;
            5'd21:   r = 5'd5;
            5'd23:   r = 5'd17;
            5'd25:   r = 5'd25;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/hc2_pipe.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hc2_pipe
// five-stage datapath: reduce and key products, determinant inverse,
// effective matrix, pair products, final mod 26
// ----------------------------------------------------------------------------
module hc2_pipe
    import hc2_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_key_cfg            i_cfg,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [LETTER_W-1:0] i_x0,
    input  wire logic [LETTER_W-1:0] i_x1,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [LETTER_W-1:0]      o_y0,
    output logic [LETTER_W-1:0]      o_y1,
    output logic                     o_invalid
);

    localparam int unsigned NSTG = 5;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] rdy;
    logic [NSTG-1:0] load;

    // stage 1
    logic [LETTER_W-1:0] r_s1_x0, r_s1_x1, r_s1_a, r_s1_b, r_s1_c, r_s1_d;
    logic [PROD_W-1:0]   r_s1_ad, r_s1_bc;
    logic                r_s1_dec;
    logic [LETTER_W-1:0] n_s1_x0, n_s1_x1, n_s1_a, n_s1_b, n_s1_c, n_s1_d;
    // stage 2
    logic [LETTER_W-1:0] r_s2_x0, r_s2_x1, r_s2_a, r_s2_b, r_s2_c, r_s2_d, r_s2_dinv;
    logic                r_s2_dec, r_s2_inv;
    logic [5:0]          n_s2_sum;
    logic [LETTER_W-1:0] n_s2_det, n_s2_dinv;
    // stage 3
    logic [LETTER_W-1:0] r_s3_x0, r_s3_x1, r_s3_m00, r_s3_m01, r_s3_m10, r_s3_m11;
    logic                r_s3_inv;
    logic [LETTER_W-1:0] n_s3_m00, n_s3_m01, n_s3_m10, n_s3_m11;
    // stage 4
    logic [SUM_W-1:0]    r_s4_s0, r_s4_s1;
    logic                r_s4_inv;
    // stage 5 (output register)
    logic [LETTER_W-1:0] r_s5_y0, r_s5_y1;
    logic                r_s5_inv;

    // a stage takes new data when empty or when its item moves on
    always_comb begin
        rdy[NSTG-1] = !r_vld[NSTG-1] || i_out_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
        load[0] = rdy[0] && i_in_valid;
        for (int k = 1; k < NSTG; k++) begin
            load[k] = rdy[k] && r_vld[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        n_s1_x0 = reduce5(i_x0);
        n_s1_x1 = reduce5(i_x1);
        n_s1_a  = reduce5(i_cfg.k00);
        n_s1_b  = reduce5(i_cfg.k01);
        n_s1_c  = reduce5(i_cfg.k10);
        n_s1_d  = reduce5(i_cfg.k11);
    end

    always_comb begin
        n_s2_sum  = 6'(mod26(11'(r_s1_ad))) + 6'(ALPHA_SIZE) - 6'(mod26(11'(r_s1_bc)));
        n_s2_det  = (n_s2_sum >= 6'(ALPHA_SIZE)) ? 5'(n_s2_sum - 6'(ALPHA_SIZE))
                                                 : n_s2_sum[LETTER_W-1:0];
        n_s2_dinv = inv26(n_s2_det);
    end

    always_comb begin
        if (r_s2_dec) begin
            n_s3_m00 = mod26(11'(10'(r_s2_d) * 10'(r_s2_dinv)));
            n_s3_m01 = mod26(11'(10'(neg26(r_s2_b)) * 10'(r_s2_dinv)));
            n_s3_m10 = mod26(11'(10'(neg26(r_s2_c)) * 10'(r_s2_dinv)));
            n_s3_m11 = mod26(11'(10'(r_s2_a) * 10'(r_s2_dinv)));
        end else begin
            n_s3_m00 = r_s2_a;
            n_s3_m01 = r_s2_b;
            n_s3_m10 = r_s2_c;
            n_s3_m11 = r_s2_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load[0]) begin
            r_s1_x0  <= n_s1_x0;
            r_s1_x1  <= n_s1_x1;
            r_s1_a   <= n_s1_a;
            r_s1_b   <= n_s1_b;
            r_s1_c   <= n_s1_c;
            r_s1_d   <= n_s1_d;
            r_s1_ad  <= 10'(n_s1_a) * 10'(n_s1_d);
            r_s1_bc  <= 10'(n_s1_b) * 10'(n_s1_c);
            r_s1_dec <= i_cfg.decrypt;
        end
        if (load[1]) begin
            r_s2_x0   <= r_s1_x0;
            r_s2_x1   <= r_s1_x1;
            r_s2_a    <= r_s1_a;
            r_s2_b    <= r_s1_b;
            r_s2_c    <= r_s1_c;
            r_s2_d    <= r_s1_d;
            r_s2_dinv <= n_s2_dinv;
            r_s2_inv  <= (n_s2_dinv == '0);
            r_s2_dec  <= r_s1_dec;
        end
        if (load[2]) begin
            r_s3_x0  <= r_s2_x0;
            r_s3_x1  <= r_s2_x1;
            r_s3_m00 <= n_s3_m00;
            r_s3_m01 <= n_s3_m01;
            r_s3_m10 <= n_s3_m10;
            r_s3_m11 <= n_s3_m11;
            r_s3_inv <= r_s2_inv;
        end
        if (load[3]) begin
            r_s4_s0  <= 11'(10'(r_s3_m00) * 10'(r_s3_x0)) + 11'(10'(r_s3_m01) * 10'(r_s3_x1));
            r_s4_s1  <= 11'(10'(r_s3_m10) * 10'(r_s3_x0)) + 11'(10'(r_s3_m11) * 10'(r_s3_x1));
            r_s4_inv <= r_s3_inv;
        end
        if (load[4]) begin
            r_s5_y0  <= r_s4_inv ? '0 : mod26(r_s4_s0);
            r_s5_y1  <= r_s4_inv ? '0 : mod26(r_s4_s1);
            r_s5_inv <= r_s4_inv;
        end
    end

    assign o_in_ready  = rdy[0];
    assign o_out_valid = r_vld[NSTG-1];
    assign o_y0        = r_s5_y0;
    assign o_y1        = r_s5_y1;
    assign o_invalid   = r_s5_inv;

    // a rejected key always yields a zero pair
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_invalid |-> o_y0 == '0 && o_y1 == '0)
        else $error("invalid key result carries nonzero letters");

    // every delivered letter lies in the alphabet
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_y0 < ALPHA_SIZE && o_y1 < ALPHA_SIZE)
        else $error("output letter out of range");

    // effective matrix entries are reduced before the pair products
    a_matrix_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> r_s3_m00 < ALPHA_SIZE && r_s3_m01 < ALPHA_SIZE
                  && r_s3_m10 < ALPHA_SIZE && r_s3_m11 < ALPHA_SIZE)
        else $error("matrix entry out of range");

    // a stage with a held item downstream keeps its item
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[3] && r_vld[4] && !i_out_ready |=> r_vld[3] && r_vld[4])
        else $error("pipeline lost an item under stall");

endmodule
`default_nettype wire

[rtl/hill_cipher_2x2_mod26.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hill_cipher_2x2_mod26
// streaming 2x2 hill cipher over a 26-letter alphabet, encrypt or decrypt
// ----------------------------------------------------------------------------
// Each item is a pair of letter codes (0 = A). In encrypt mode the pair is
// multiplied by the 2x2 key mod 26; in decrypt mode by the inverse key, the
// determinant's inverse mod 26 times the adjugate. When the determinant has
// no inverse mod 26 the result raises key_invalid and both letters are zero.
// Codes 26..31 on the key or the letters count as their value mod 26. The
// datapath is a five-stage pipeline: one item is taken every cycle unless
// the input side stalls, which it does only when the output is held and
// every stage is full. Key and mode go through the plain register port (index
// 0..3 key entries row by row, index 4 decrypt mode, other indexes ignored);
// the user must write them only while no item is in flight, which the block
// does not enforce; each item derives its own effective matrix as it passes.
// ----------------------------------------------------------------------------
module hill_cipher_2x2_mod26
    import hc2_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration write port
    input  wire logic                  i_cfg_wen,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // letter pair in
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [LETTER_W-1:0]   i_letter_first,
    input  wire logic [LETTER_W-1:0]   i_letter_second,
    // transformed pair out
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [LETTER_W-1:0]        o_out_first,
    output logic [LETTER_W-1:0]        o_out_second,
    output logic                       o_key_invalid
);

    // key and mode registers, reset to identity key in encrypt mode
    t_key_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.k00     <= 5'd1;
            r_cfg.k01     <= 5'd0;
            r_cfg.k10     <= 5'd0;
            r_cfg.k11     <= 5'd1;
            r_cfg.decrypt <= 1'b0;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                CFG_KEY_R0C0: r_cfg.k00     <= i_cfg_wdata;
                CFG_KEY_R0C1: r_cfg.k01     <= i_cfg_wdata;
                CFG_KEY_R1C0: r_cfg.k10     <= i_cfg_wdata;
                CFG_KEY_R1C1: r_cfg.k11     <= i_cfg_wdata;
                CFG_DECRYPT:  r_cfg.decrypt <= i_cfg_wdata[0];
                default: begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // pipelined datapath: key reduction, determinant inverse, matrix,
    // pair products, final reduction into the output register
    hc2_pipe u_pipe (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_x0        (i_letter_first),
        .i_x1        (i_letter_second),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_y0        (o_out_first),
        .o_y1        (o_out_second),
        .o_invalid   (o_key_invalid)
    );

endmodule
`default_nettype wire
